// File: src/pbss_pkg.sv
package pbss_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int VOL_WINDOW = 20;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HELD_W     = $clog2(HIST_DEPTH + 1);

  localparam int PER_W   = 6;
  localparam int SCORE_W = 15;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;

  localparam int VSUM_W = 32 + $clog2(VOL_WINDOW + 1);
  localparam int LHS_W  = 32 + $clog2(VOL_WINDOW * 256 + 1);
  localparam int RHS_W  = 16 + VSUM_W;
  localparam int CSUM_W = 32 + PER_W;
  localparam int PROD_W = CSUM_W + PER_W;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 48;
  localparam int Q_W    = 16;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 15'd25600;
  localparam logic [SCORE_W-1:0] BO_BASE   = 15'd15360;
  localparam logic [SCORE_W-1:0] SP_BASE   = 15'd12800;
  localparam logic [SCORE_W-1:0] CR_BASE   = 15'd14080;
  localparam int BO_GAIN = 10240;
  localparam int SP_GAIN = 5;
  localparam int CR_GAIN = 128000;

  localparam logic [1:0] SIG_BREAKOUT = 2'd0;
  localparam logic [1:0] SIG_SPIKE    = 2'd1;
  localparam logic [1:0] SIG_CROSS    = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_BO_PERIOD   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_FAST_PERIOD = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SLOW_PERIOD = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SPIKE_MULT  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MIN_SCORE   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_ENABLE      = 3'd5;

  typedef enum logic [1:0] {WM_BO, WM_SP, WM_CR} walk_mode_t;
  typedef enum logic [1:0] {DS_BO, DS_SP1, DS_SP2, DS_CR} div_sel_t;
  typedef enum logic [2:0] {FIN_NONE, FIN_BO, FIN_SP1, FIN_SP2, FIN_CR} fin_t;

  typedef struct packed {
    logic [31:0] high;
    logic [31:0] low;
    logic [31:0] close;
    logic [31:0] vol;
  } bar_t;

  typedef struct packed {
    logic               cap;
    logic               bar_wr;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_k;
    walk_mode_t         mode;
    logic               div_start;
    div_sel_t           div_sel;
    fin_t               fin;
    logic               out_load;
    logic [1:0]         out_pos;
  } cmd_t;

  typedef struct packed {
    logic               bo_ok;
    logic               sp_ok;
    logic               cr_ok;
    logic [2:0]         en;
    logic [HIST_AW-1:0] bo_kend;
    logic [HIST_AW-1:0] cr_kend;
    logic               bo_hit;
    logic               bo_span;
    logic               sp_hit;
    logic               cr_hit;
    logic               div_busy;
    logic [1:0]         n_pass;
  } stat_t;

endpackage

// File: src/price_bar_signal_scanner.sv
// Channel  | Direction | Handshake             | Carries
// in_      | input     | in_valid / in_ready   | one bar append or one tick request
// out_     | output    | out_valid / out_ready | one scored signal, out_last on the final
// cfg_     | input     | cfg_we                | register write, index and data
//
// A tick request walks the bar history for each enabled check, limited by the single
// read port of the bar history and the one-bit-per-cycle divider, then emits its
// signals one per cycle unless the output stalls.
// Reset is synchronous and active low; the history contents are not cleared.
// New requests are taken only once every signal of the previous tick has been delivered.
module price_bar_signal_scanner (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [15:0]                 in_symbol_id,
  input  logic [31:0]                 in_price,
  input  logic [31:0]                 in_volume,
  input  logic [31:0]                 in_bar_high,
  input  logic [31:0]                 in_bar_low,
  input  logic [47:0]                 in_timestamp_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic                        out_direction,
  output logic [14:0]                 out_score,
  output logic [15:0]                 out_ratio_whole,
  output logic [15:0]                 out_symbol,
  output logic [31:0]                 out_price,
  output logic [31:0]                 out_volume,
  output logic [47:0]                 out_time,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [pbss_pkg::CFG_IW-1:0] cfg_index,
  input  logic [pbss_pkg::CFG_DW-1:0] cfg_wdata
);

  pbss_pkg::cmd_t  cmd;
  pbss_pkg::stat_t stat;

  pbss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_symbol_id    (in_symbol_id),
    .in_price        (in_price),
    .in_volume       (in_volume),
    .in_bar_high     (in_bar_high),
    .in_bar_low      (in_bar_low),
    .in_timestamp_ms (in_timestamp_ms),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_kind        (out_kind),
    .out_direction   (out_direction),
    .out_score       (out_score),
    .out_ratio_whole (out_ratio_whole),
    .out_symbol      (out_symbol),
    .out_price       (out_price),
    .out_volume      (out_volume),
    .out_time        (out_time),
    .out_last        (out_last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while signals are pending");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !in_ready)
    else $error("history walk outside a tick");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("final signal did not end the tick");

  a_div_idle_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.div_busy)
    else $error("signal loaded while a division runs");

endmodule

// File: src/pbss_div.sv
module pbss_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pbss_pkg::NUM_W-1:0]  num,
  input  logic [pbss_pkg::DEN_W-1:0]  den,
  output logic                        busy,
  output logic [pbss_pkg::Q_W-1:0]    quot
);

  localparam int CW = $clog2(pbss_pkg::Q_W);

  logic [pbss_pkg::NUM_W-1:0] rem_r;
  logic [pbss_pkg::NUM_W-1:0] dsh_r;
  logic [pbss_pkg::Q_W-1:0]   quot_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic [pbss_pkg::NUM_W-1:0] den_top;

  // Divisor aligned to the top quotient bit; a numerator beyond it saturates.
  assign den_top = {den, {pbss_pkg::Q_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      if (num >= den_top) begin
        quot_r <= '1;
        busy_r <= 1'b0;
      end else begin
        rem_r  <= num;
        dsh_r  <= den_top >> 1;
        quot_r <= '0;
        cnt_r  <= CW'(pbss_pkg::Q_W - 1);
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_r  <= rem_r - dsh_r;
        quot_r <= {quot_r[pbss_pkg::Q_W-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[pbss_pkg::Q_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

// File: src/pbss_dp.sv
module pbss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [15:0]                   in_symbol_id,
  input  logic [31:0]                   in_price,
  input  logic [31:0]                   in_volume,
  input  logic [31:0]                   in_bar_high,
  input  logic [31:0]                   in_bar_low,
  input  logic [47:0]                   in_timestamp_ms,
  input  logic                          cfg_we,
  input  logic [pbss_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [pbss_pkg::CFG_DW-1:0]   cfg_wdata,
  input  pbss_pkg::cmd_t                cmd,
  output pbss_pkg::stat_t               stat,
  output logic [1:0]                    out_kind,
  output logic                          out_direction,
  output logic [14:0]                   out_score,
  output logic [15:0]                   out_ratio_whole,
  output logic [15:0]                   out_symbol,
  output logic [31:0]                   out_price,
  output logic [31:0]                   out_volume,
  output logic [47:0]                   out_time,
  output logic                          out_last
);

  localparam int AW = pbss_pkg::HIST_AW;

  pbss_pkg::bar_t mem [pbss_pkg::HIST_DEPTH];
  pbss_pkg::bar_t rd_r;
  logic                       rd_v_r;
  logic [AW-1:0]              rd_k_r;
  pbss_pkg::walk_mode_t       rd_m_r;
  logic [AW-1:0]              ws_r;
  logic [pbss_pkg::HELD_W-1:0] held_r;
  logic [AW:0]                slot_t;
  logic [AW-1:0]              rd_addr;

  logic [pbss_pkg::PER_W-1:0]   bp_r, fp_r, sp_r;
  logic [15:0]                  mult_r;
  logic [pbss_pkg::SCORE_W-1:0] min_r;
  logic [2:0]                   en_r;

  logic [15:0] t_sym_r;
  logic [31:0] t_price_r, t_vol_r;
  logic [47:0] t_time_r;

  logic [31:0]                 hi_r, lo_r;
  logic [pbss_pkg::VSUM_W-1:0] vsum_r;
  logic [pbss_pkg::CSUM_W-1:0] fn_r, sn_r, fpv_r, spv_r;
  logic [pbss_pkg::LHS_W-1:0]  lhs_r;
  logic [pbss_pkg::RHS_W-1:0]  rhs_r;
  logic [pbss_pkg::PROD_W-1:0] anow_r, bnow_r, aprev_r, bprev_r;

  logic                         f_v_r   [3];
  logic                         f_dir_r [3];
  logic [pbss_pkg::SCORE_W-1:0] f_sc_r  [3];
  logic [15:0]                  ratio_r;

  logic                        bull, bear, golden, death;
  logic [31:0]                 gap;
  logic [pbss_pkg::PROD_W-1:0] diff;
  logic [pbss_pkg::NUM_W-1:0]  div_num;
  logic [pbss_pkg::DEN_W-1:0]  div_den;
  logic                        div_busy;
  logic [pbss_pkg::Q_W-1:0]    q;
  logic [15:0]                 k16;

  logic [2:0] pass;
  logic [1:0] rank [3];
  logic [1:0] n_pass;
  logic [1:0] sel;

  // Slot of the k-th newest bar.
  always_comb begin
    slot_t = {1'b0, ws_r} + (AW+1)'(pbss_pkg::HIST_DEPTH - 1) - {1'b0, cmd.rd_k};
    if (slot_t >= (AW+1)'(pbss_pkg::HIST_DEPTH)) begin
      rd_addr = AW'(slot_t - (AW+1)'(pbss_pkg::HIST_DEPTH));
    end else begin
      rd_addr = slot_t[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bar_wr) begin
      mem[ws_r] <= {in_bar_high, in_bar_low, in_price, in_volume};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      ws_r   <= '0;
      held_r <= '0;
      bp_r   <= 6'd20;
      fp_r   <= 6'd10;
      sp_r   <= 6'd50;
      mult_r <= 16'd768;
      min_r  <= '0;
      en_r   <= 3'd7;
    end else begin
      rd_v_r <= cmd.rd_en;
      if (cmd.bar_wr) begin
        ws_r <= (ws_r == AW'(pbss_pkg::HIST_DEPTH - 1)) ? '0 : ws_r + 1'b1;
        if (held_r != pbss_pkg::HELD_W'(pbss_pkg::HIST_DEPTH)) begin
          held_r <= held_r + 1'b1;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pbss_pkg::CFG_BO_PERIOD:   bp_r   <= cfg_wdata[pbss_pkg::PER_W-1:0];
          pbss_pkg::CFG_FAST_PERIOD: fp_r   <= cfg_wdata[pbss_pkg::PER_W-1:0];
          pbss_pkg::CFG_SLOW_PERIOD: sp_r   <= cfg_wdata[pbss_pkg::PER_W-1:0];
          pbss_pkg::CFG_SPIKE_MULT:  mult_r <= cfg_wdata;
          pbss_pkg::CFG_MIN_SCORE:   min_r  <= cfg_wdata[pbss_pkg::SCORE_W-1:0];
          pbss_pkg::CFG_ENABLE:      en_r   <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  assign k16 = 16'(rd_k_r);

  always_ff @(posedge clk) begin
    rd_k_r <= cmd.rd_k;
    rd_m_r <= cmd.mode;
    if (cmd.cap) begin
      t_sym_r   <= in_symbol_id;
      t_price_r <= in_price;
      t_vol_r   <= in_volume;
      t_time_r  <= in_timestamp_ms;
      hi_r      <= '0;
      lo_r      <= '1;
      vsum_r    <= '0;
      fn_r      <= '0;
      sn_r      <= '0;
      fpv_r     <= '0;
      spv_r     <= '0;
    end else if (rd_v_r) begin
      case (rd_m_r)
        pbss_pkg::WM_BO: begin
          if (rd_r.high > hi_r) hi_r <= rd_r.high;
          if (rd_r.low < lo_r) lo_r <= rd_r.low;
        end
        pbss_pkg::WM_SP: begin
          vsum_r <= vsum_r + pbss_pkg::VSUM_W'(rd_r.vol);
        end
        pbss_pkg::WM_CR: begin
          if (k16 < 16'(fp_r)) fn_r <= fn_r + pbss_pkg::CSUM_W'(rd_r.close);
          if (k16 < 16'(sp_r)) sn_r <= sn_r + pbss_pkg::CSUM_W'(rd_r.close);
          if (k16 >= 16'd1 && k16 <= 16'(fp_r)) begin
            fpv_r <= fpv_r + pbss_pkg::CSUM_W'(rd_r.close);
          end
          if (k16 >= 16'd1 && k16 <= 16'(sp_r)) begin
            spv_r <= spv_r + pbss_pkg::CSUM_W'(rd_r.close);
          end
        end
        default: ;
      endcase
    end
  end

  // Products are registered in the cycle after the last accumulation of a walk.
  always_ff @(posedge clk) begin
    lhs_r   <= pbss_pkg::LHS_W'(t_vol_r) * pbss_pkg::LHS_W'(pbss_pkg::VOL_WINDOW * 256);
    rhs_r   <= pbss_pkg::RHS_W'(mult_r) * pbss_pkg::RHS_W'(vsum_r);
    anow_r  <= pbss_pkg::PROD_W'(fn_r) * pbss_pkg::PROD_W'(sp_r);
    bnow_r  <= pbss_pkg::PROD_W'(sn_r) * pbss_pkg::PROD_W'(fp_r);
    aprev_r <= pbss_pkg::PROD_W'(fpv_r) * pbss_pkg::PROD_W'(sp_r);
    bprev_r <= pbss_pkg::PROD_W'(spv_r) * pbss_pkg::PROD_W'(fp_r);
  end

  always_comb begin
    bull   = t_price_r > hi_r;
    bear   = t_price_r < lo_r;
    gap    = bull ? t_price_r - hi_r : lo_r - t_price_r;
    golden = (aprev_r <= bprev_r) && (anow_r > bnow_r);
    death  = (aprev_r >= bprev_r) && (anow_r < bnow_r);
    diff   = (anow_r > bnow_r) ? anow_r - bnow_r : bnow_r - anow_r;
  end

  always_comb begin
    case (cmd.div_sel)
      pbss_pkg::DS_BO: begin
        div_num = pbss_pkg::NUM_W'(gap) * pbss_pkg::NUM_W'(pbss_pkg::BO_GAIN);
        div_den = pbss_pkg::DEN_W'(hi_r - lo_r);
      end
      pbss_pkg::DS_SP1: begin
        div_num = pbss_pkg::NUM_W'(pbss_pkg::LHS_W'(pbss_pkg::RHS_W'(lhs_r) - rhs_r))
                  * pbss_pkg::NUM_W'(pbss_pkg::SP_GAIN);
        div_den = pbss_pkg::DEN_W'(vsum_r);
      end
      pbss_pkg::DS_SP2: begin
        div_num = pbss_pkg::NUM_W'(t_vol_r) * pbss_pkg::NUM_W'(pbss_pkg::VOL_WINDOW);
        div_den = pbss_pkg::DEN_W'(vsum_r);
      end
      pbss_pkg::DS_CR: begin
        div_num = pbss_pkg::NUM_W'(diff) * pbss_pkg::NUM_W'(pbss_pkg::CR_GAIN);
        div_den = pbss_pkg::DEN_W'(bnow_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  pbss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      f_v_r[0] <= 1'b0;
      f_v_r[1] <= 1'b0;
      f_v_r[2] <= 1'b0;
    end else begin
      case (cmd.fin)
        pbss_pkg::FIN_BO: begin
          f_v_r[0]   <= 1'b1;
          f_dir_r[0] <= !bull;
          if (!(hi_r > lo_r)) begin
            f_sc_r[0] <= pbss_pkg::BO_BASE;
          end else if (q >= pbss_pkg::Q_W'(pbss_pkg::SCORE_MAX - pbss_pkg::BO_BASE)) begin
            f_sc_r[0] <= pbss_pkg::SCORE_MAX;
          end else begin
            f_sc_r[0] <= pbss_pkg::BO_BASE + pbss_pkg::SCORE_W'(q);
          end
        end
        pbss_pkg::FIN_SP1: begin
          f_dir_r[1] <= 1'b0;
          if (q >= pbss_pkg::Q_W'(pbss_pkg::SCORE_MAX - pbss_pkg::SP_BASE)) begin
            f_sc_r[1] <= pbss_pkg::SCORE_MAX;
          end else begin
            f_sc_r[1] <= pbss_pkg::SP_BASE + pbss_pkg::SCORE_W'(q);
          end
        end
        pbss_pkg::FIN_SP2: begin
          f_v_r[1] <= 1'b1;
          ratio_r  <= q;
        end
        pbss_pkg::FIN_CR: begin
          f_v_r[2]   <= 1'b1;
          f_dir_r[2] <= !golden;
          if (q >= pbss_pkg::Q_W'(pbss_pkg::SCORE_MAX - pbss_pkg::CR_BASE)) begin
            f_sc_r[2] <= pbss_pkg::SCORE_MAX;
          end else begin
            f_sc_r[2] <= pbss_pkg::CR_BASE + pbss_pkg::SCORE_W'(q);
          end
        end
        default: ;
      endcase
    end
  end

  // Stable descending order: an equal score from an earlier check ranks first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pass[i] = f_v_r[i] && (f_sc_r[i] >= min_r);
    end
    for (int i = 0; i < 3; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 3; j++) begin
        if (j != i && pass[j] &&
            (f_sc_r[j] > f_sc_r[i] || (f_sc_r[j] == f_sc_r[i] && j < i))) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    n_pass = 2'($countones(pass));
    sel = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (pass[i] && rank[i] == cmd.out_pos) sel = 2'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind        <= sel;
      out_direction   <= f_dir_r[sel];
      out_score       <= f_sc_r[sel];
      out_ratio_whole <= (sel == pbss_pkg::SIG_SPIKE) ? ratio_r : 16'd0;
      out_symbol      <= t_sym_r;
      out_price       <= t_price_r;
      out_volume      <= t_vol_r;
      out_time        <= t_time_r;
      out_last        <= (cmd.out_pos == n_pass - 2'd1);
    end
  end

  always_comb begin
    stat.bo_ok    = (bp_r != '0) && (16'(held_r) >= 16'(bp_r) + 16'd1);
    stat.sp_ok    = 16'(held_r) >= 16'(pbss_pkg::VOL_WINDOW);
    stat.cr_ok    = (fp_r != '0) && (sp_r != '0) &&
                    (16'(held_r) >= 16'(sp_r) + 16'd2) &&
                    (16'(held_r) >= 16'(fp_r) + 16'd1);
    stat.en       = en_r;
    stat.bo_kend  = AW'(bp_r);
    stat.cr_kend  = (fp_r > sp_r) ? AW'(fp_r) : AW'(sp_r);
    stat.bo_hit   = bull || bear;
    stat.bo_span  = hi_r > lo_r;
    stat.sp_hit   = (vsum_r != '0) && (pbss_pkg::RHS_W'(lhs_r) >= rhs_r);
    stat.cr_hit   = (fn_r != '0) && (sn_r != '0) && (fpv_r != '0) && (spv_r != '0) &&
                    (golden || death);
    stat.div_busy = div_busy;
    stat.n_pass   = n_pass;
  end

endmodule

// File: src/pbss_ctrl.sv
module pbss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pbss_pkg::stat_t  stat,
  output pbss_pkg::cmd_t   cmd
);

  localparam int AW = pbss_pkg::HIST_AW;

  typedef enum logic [4:0] {
    S_IDLE, S_BO_START, S_SP_START, S_CR_START, S_WALK, S_DRAIN,
    S_BO_EVAL, S_BO_DIV, S_SP_MUL, S_SP_CMP, S_SP_DIV1, S_SP_DIV2,
    S_CR_MUL, S_CR_CMP, S_CR_DIV, S_EMIT, S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        k_r, k_nxt, kend_r, kend_nxt;
  pbss_pkg::walk_mode_t mode_r, mode_nxt;
  logic [1:0]           pos_r, pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    kend_nxt      = kend_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.rd_k      = k_r;
    cmd.mode      = mode_r;
    cmd.div_sel   = pbss_pkg::DS_BO;
    cmd.fin       = pbss_pkg::FIN_NONE;
    cmd.out_pos   = pos_r;
    case (state_r)
      S_IDLE: begin
        cmd.cap    = accept && in_action;
        cmd.bar_wr = accept && !in_action;
        if (accept && in_action) state_nxt = S_BO_START;
      end
      S_BO_START: begin
        if (stat.en[0] && stat.bo_ok) begin
          k_nxt     = AW'(1);
          kend_nxt  = stat.bo_kend;
          mode_nxt  = pbss_pkg::WM_BO;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_SP_START;
        end
      end
      S_SP_START: begin
        if (stat.en[1] && stat.sp_ok) begin
          k_nxt     = '0;
          kend_nxt  = AW'(pbss_pkg::VOL_WINDOW - 1);
          mode_nxt  = pbss_pkg::WM_SP;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_CR_START;
        end
      end
      S_CR_START: begin
        if (stat.en[2] && stat.cr_ok) begin
          k_nxt     = '0;
          kend_nxt  = stat.cr_kend;
          mode_nxt  = pbss_pkg::WM_CR;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WALK: begin
        cmd.rd_en = 1'b1;
        if (k_r == kend_r) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        case (mode_r)
          pbss_pkg::WM_BO: state_nxt = S_BO_EVAL;
          pbss_pkg::WM_SP: state_nxt = S_SP_MUL;
          default:         state_nxt = S_CR_MUL;
        endcase
      end
      S_BO_EVAL: begin
        if (!stat.bo_hit) begin
          state_nxt = S_SP_START;
        end else if (stat.bo_span) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_BO_DIV;
        end else begin
          cmd.fin   = pbss_pkg::FIN_BO;
          state_nxt = S_SP_START;
        end
      end
      S_BO_DIV: begin
        if (!stat.div_busy) begin
          cmd.fin   = pbss_pkg::FIN_BO;
          state_nxt = S_SP_START;
        end
      end
      S_SP_MUL: state_nxt = S_SP_CMP;
      S_SP_CMP: begin
        cmd.div_sel = pbss_pkg::DS_SP1;
        if (stat.sp_hit) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_SP_DIV1;
        end else begin
          state_nxt = S_CR_START;
        end
      end
      S_SP_DIV1: begin
        cmd.div_sel = pbss_pkg::DS_SP2;
        if (!stat.div_busy) begin
          cmd.fin       = pbss_pkg::FIN_SP1;
          cmd.div_start = 1'b1;
          state_nxt     = S_SP_DIV2;
        end
      end
      S_SP_DIV2: begin
        if (!stat.div_busy) begin
          cmd.fin   = pbss_pkg::FIN_SP2;
          state_nxt = S_CR_START;
        end
      end
      S_CR_MUL: state_nxt = S_CR_CMP;
      S_CR_CMP: begin
        cmd.div_sel = pbss_pkg::DS_CR;
        if (stat.cr_hit) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_CR_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CR_DIV: begin
        if (!stat.div_busy) begin
          cmd.fin   = pbss_pkg::FIN_CR;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.n_pass == 2'd0) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.out_load  = 1'b1;
          cmd.out_pos   = 2'd0;
          pos_nxt       = 2'd0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (pos_r == stat.n_pass - 2'd1) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            pos_nxt      = pos_r + 2'd1;
            cmd.out_load = 1'b1;
            cmd.out_pos  = pos_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      kend_r      <= '0;
      mode_r      <= pbss_pkg::WM_BO;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      kend_r      <= kend_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: tb/price_bar_signal_scanner_tb.sv
module price_bar_signal_scanner_tb;

  typedef struct {
    bit        act;
    bit [15:0] sym;
    bit [31:0] price;
    bit [31:0] vol;
    bit [31:0] hi;
    bit [31:0] lo;
    bit [47:0] ts;
  } request_t;

  typedef struct {
    bit [1:0]  kind;
    bit        dir;
    bit [14:0] score;
    bit [15:0] ratio;
    bit [15:0] sym;
    bit [31:0] price;
    bit [31:0] vol;
    bit [47:0] ts;
    bit        last;
  } signal_t;

  // A register index past the end of the list; writes to it are ignored.
  localparam logic [pbss_pkg::CFG_IW-1:0] CFG_SPARE = 3'd6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic [15:0] in_symbol_id;
  logic [31:0] in_price;
  logic [31:0] in_volume;
  logic [31:0] in_bar_high;
  logic [31:0] in_bar_low;
  logic [47:0] in_timestamp_ms;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_kind;
  logic out_direction;
  logic [14:0] out_score;
  logic [15:0] out_ratio_whole;
  logic [15:0] out_symbol;
  logic [31:0] out_price;
  logic [31:0] out_volume;
  logic [47:0] out_time;
  logic out_last;
  logic cfg_we;
  logic [pbss_pkg::CFG_IW-1:0] cfg_index;
  logic [pbss_pkg::CFG_DW-1:0] cfg_wdata;

  price_bar_signal_scanner dut (.*);

  // Scoreboard copy of the bar history and registers.
  bit [31:0] hist_high [pbss_pkg::HIST_DEPTH];
  bit [31:0] hist_low [pbss_pkg::HIST_DEPTH];
  bit [31:0] hist_close [pbss_pkg::HIST_DEPTH];
  bit [31:0] hist_vol [pbss_pkg::HIST_DEPTH];
  int unsigned wr_slot;
  int unsigned bars_kept;
  int unsigned bo_period, fast_period, slow_period, spike_mult, score_floor, enables;

  request_t pending_requests[$];
  signal_t expected_signals[$];
  int errors;
  int n_bars, n_ticks, n_signals;
  int send_idle, recv_idle;
  bit recv_hold;
  bit long_stall_go;
  longint gen_close;
  int trend;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned slot_back(int unsigned k);
    return (wr_slot + pbss_pkg::HIST_DEPTH - 1 - k) % pbss_pkg::HIST_DEPTH;
  endfunction

  function automatic longint unsigned close_total(int unsigned len, int unsigned skip);
    longint unsigned s;
    s = 0;
    for (int unsigned k = skip; k < skip + len; k++) s += hist_close[slot_back(k)];
    return s;
  endfunction

  function automatic signal_t make_signal(bit [1:0] kind, bit dir, longint unsigned score,
                                          longint unsigned ratio);
    signal_t s;
    s.kind = kind;
    s.dir = dir;
    s.score = score[14:0];
    s.ratio = ratio[15:0];
    s.last = 1'b0;
    return s;
  endfunction

  // Applies one accepted request to the scoreboard state and queues its signals.
  task automatic scan_request(request_t r);
    signal_t found[$];
    signal_t t;
    longint unsigned hi, lo, level, gap, score, extra, sum, lhs, rhs, whole;
    longint unsigned fn, sn, fpv, spv, a_now, b_now, a_prev, b_prev, diff;
    bit bull, bear, golden, death;
    int j;
    if (!r.act) begin
      hist_high[wr_slot] = r.hi;
      hist_low[wr_slot] = r.lo;
      hist_close[wr_slot] = r.price;
      hist_vol[wr_slot] = r.vol;
      wr_slot = (wr_slot + 1) % pbss_pkg::HIST_DEPTH;
      if (bars_kept < pbss_pkg::HIST_DEPTH) bars_kept++;
      n_bars++;
      return;
    end
    n_ticks++;
    if (enables[0] && bo_period != 0 && bars_kept >= bo_period + 1) begin
      hi = 0;
      lo = 64'hFFFF_FFFF;
      for (int unsigned k = 1; k <= bo_period; k++) begin
        if (hist_high[slot_back(k)] > hi) hi = hist_high[slot_back(k)];
        if (hist_low[slot_back(k)] < lo) lo = hist_low[slot_back(k)];
      end
      bull = r.price > hi;
      bear = r.price < lo;
      if (bull || bear) begin
        level = bull ? hi : lo;
        gap = (r.price > level) ? r.price - level : level - r.price;
        score = pbss_pkg::BO_BASE;
        if (hi > lo) begin
          extra = gap * pbss_pkg::BO_GAIN / (hi - lo);
          score = (extra >= pbss_pkg::SCORE_MAX - pbss_pkg::BO_BASE) ? pbss_pkg::SCORE_MAX :
                  score + extra;
        end
        if (score >= score_floor)
          found = {found, make_signal(pbss_pkg::SIG_BREAKOUT, !bull, score, 0)};
      end
    end
    if (enables[1] && bars_kept >= pbss_pkg::VOL_WINDOW) begin
      sum = 0;
      for (int unsigned k = 0; k < pbss_pkg::VOL_WINDOW; k++) sum += hist_vol[slot_back(k)];
      lhs = longint'(r.vol) * pbss_pkg::VOL_WINDOW * 256;
      rhs = longint'(spike_mult) * sum;
      if (sum != 0 && lhs >= rhs) begin
        extra = pbss_pkg::SP_GAIN * (lhs - rhs) / sum;
        score = (extra >= pbss_pkg::SCORE_MAX - pbss_pkg::SP_BASE) ? pbss_pkg::SCORE_MAX :
                pbss_pkg::SP_BASE + extra;
        whole = longint'(r.vol) * pbss_pkg::VOL_WINDOW / sum;
        if (whole > 65535) whole = 65535;
        if (score >= score_floor)
          found = {found, make_signal(pbss_pkg::SIG_SPIKE, 1'b0, score, whole)};
      end
    end
    if (enables[2] && fast_period != 0 && slow_period != 0 &&
        bars_kept >= slow_period + 2 && bars_kept >= fast_period + 1) begin
      fn = close_total(fast_period, 0);
      sn = close_total(slow_period, 0);
      fpv = close_total(fast_period, 1);
      spv = close_total(slow_period, 1);
      if (fn != 0 && sn != 0 && fpv != 0 && spv != 0) begin
        a_now = fn * slow_period;
        b_now = sn * fast_period;
        a_prev = fpv * slow_period;
        b_prev = spv * fast_period;
        golden = a_prev <= b_prev && a_now > b_now;
        death = a_prev >= b_prev && a_now < b_now;
        if (golden || death) begin
          diff = (a_now > b_now) ? a_now - b_now : b_now - a_now;
          extra = diff * pbss_pkg::CR_GAIN / b_now;
          score = (extra >= pbss_pkg::SCORE_MAX - pbss_pkg::CR_BASE) ? pbss_pkg::SCORE_MAX :
                  pbss_pkg::CR_BASE + extra;
          if (score >= score_floor)
            found = {found, make_signal(pbss_pkg::SIG_CROSS, death, score, 0)};
        end
      end
    end
    // Stable insertion sort so that equal scores keep check order.
    for (int i = 1; i < found.size(); i++) begin
      t = found[i];
      j = i - 1;
      while (j >= 0 && found[j].score < t.score) begin
        found[j + 1] = found[j];
        j--;
      end
      found[j + 1] = t;
    end
    foreach (found[i]) begin
      t = found[i];
      t.sym = r.sym;
      t.price = r.price;
      t.vol = r.vol;
      t.ts = r.ts;
      t.last = (i == found.size() - 1);
      expected_signals = {expected_signals, t};
    end
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: one request on the input channel at a time.
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r.act = in_action;
        r.sym = in_symbol_id;
        r.price = in_price;
        r.vol = in_volume;
        r.hi = in_bar_high;
        r.lo = in_bar_low;
        r.ts = in_timestamp_ms;
        scan_request(r);
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
          r = pending_requests.pop_front();
          in_action <= r.act;
          in_symbol_id <= r.sym;
          in_price <= r.price;
          in_volume <= r.vol;
          in_bar_high <= r.hi;
          in_bar_low <= r.lo;
          in_timestamp_ms <= r.ts;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each delivered signal with the oldest prediction.
  always @(posedge clk) begin
    signal_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        n_signals++;
        if (expected_signals.size() == 0) begin
          report_mismatch("unexpected signal, score", out_score, 0);
        end else begin
          e = expected_signals.pop_front();
          if (out_kind != e.kind) report_mismatch("kind", out_kind, e.kind);
          if (out_direction != e.dir) report_mismatch("direction", out_direction, e.dir);
          if (out_score != e.score) report_mismatch("score", out_score, e.score);
          if (out_ratio_whole != e.ratio) report_mismatch("ratio_whole", out_ratio_whole, e.ratio);
          if (out_symbol != e.sym) report_mismatch("symbol", out_symbol, e.sym);
          if (out_price != e.price) report_mismatch("price", out_price, e.price);
          if (out_volume != e.vol) report_mismatch("volume", out_volume, e.vol);
          if (out_time != e.ts) report_mismatch("time", out_time, e.ts);
          if (out_last != e.last) report_mismatch("last", out_last, e.last);
        end
      end
    end
  end

  // Long receiver hold-off, so that a tick backs up and the input stalls.
  always @(posedge long_stall_go) begin
    recv_hold <= 1'b1;
    repeat (900) @(posedge clk);
    recv_hold <= 1'b0;
  end

  function automatic request_t bar_request(bit [31:0] hi, bit [31:0] lo, bit [31:0] cl,
                                           bit [31:0] vol);
    request_t r;
    r.act = 1'b0;
    r.sym = 16'($urandom);
    r.price = cl;
    r.vol = vol;
    r.hi = hi;
    r.lo = lo;
    r.ts = 48'({$urandom, $urandom});
    return r;
  endfunction

  function automatic request_t tick_request(bit [31:0] price, bit [31:0] vol);
    request_t r;
    r = bar_request($urandom, $urandom, price, vol);
    r.act = 1'b1;
    return r;
  endfunction

  // Trending random walk, so that the averages cross now and then.
  function automatic request_t random_bar(bit quiet);
    int unsigned spread;
    if (quiet) return bar_request(0, 0, 0, 0);
    if ($urandom_range(7) == 0) trend = -trend;
    gen_close += trend * longint'($urandom_range(6000)) + longint'($urandom_range(4000)) - 2000;
    if (gen_close < 100000) gen_close = 100000;
    if (gen_close > 64'd4000000000) gen_close = 64'd4000000000;
    spread = $urandom_range(5000);
    if ($urandom_range(19) == 0)
      return bar_request($urandom, $urandom, $urandom, $urandom);
    return bar_request(32'(gen_close + spread), 32'(gen_close - $urandom_range(5000)),
                       32'(gen_close), $urandom_range(3000, 500));
  endfunction

  function automatic request_t random_tick();
    bit [31:0] p, v;
    p = 32'(gen_close + longint'($urandom_range(40000)) - 20000);
    if ($urandom_range(9) == 0) p = $urandom;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom_range(300000, 4000);
      3:       v = $urandom;
      default: v = $urandom_range(3000, 500);
    endcase
    return tick_request(p, v);
  endfunction

  task automatic queue_request(request_t r);
    pending_requests = {pending_requests, r};
  endtask

  task automatic queue_random(int count, int tick_pct);
    for (int i = 0; i < count; i++)
      queue_request(($urandom_range(99) < tick_pct) ? random_tick() : random_bar(1'b0));
  endtask

  // Waits until the scanner has nothing left to do, then lets a tick finish.
  task automatic settle();
    while (pending_requests.size() > 0 || in_valid || expected_signals.size() > 0)
      @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [pbss_pkg::CFG_IW-1:0] idx,
                           logic [pbss_pkg::CFG_DW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      pbss_pkg::CFG_BO_PERIOD:   bo_period = value[5:0];
      pbss_pkg::CFG_FAST_PERIOD: fast_period = value[5:0];
      pbss_pkg::CFG_SLOW_PERIOD: slow_period = value[5:0];
      pbss_pkg::CFG_SPIKE_MULT:  spike_mult = value;
      pbss_pkg::CFG_MIN_SCORE:   score_floor = value[14:0];
      pbss_pkg::CFG_ENABLE:      enables = value[2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [pbss_pkg::CFG_DW-1:0] bo, logic [pbss_pkg::CFG_DW-1:0] fp,
                           logic [pbss_pkg::CFG_DW-1:0] sp, logic [pbss_pkg::CFG_DW-1:0] mult,
                           logic [pbss_pkg::CFG_DW-1:0] mins, logic [pbss_pkg::CFG_DW-1:0] en);
    write_reg(pbss_pkg::CFG_BO_PERIOD, bo);
    write_reg(pbss_pkg::CFG_FAST_PERIOD, fp);
    write_reg(pbss_pkg::CFG_SLOW_PERIOD, sp);
    write_reg(pbss_pkg::CFG_SPIKE_MULT, mult);
    write_reg(pbss_pkg::CFG_MIN_SCORE, mins);
    write_reg(pbss_pkg::CFG_ENABLE, en);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_action = 1'b0;
    in_symbol_id = '0;
    in_price = '0;
    in_volume = '0;
    in_bar_high = '0;
    in_bar_low = '0;
    in_timestamp_ms = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    recv_hold = 1'b0;
    long_stall_go = 1'b0;
    errors = 0;
    n_bars = 0;
    n_ticks = 0;
    n_signals = 0;
    wr_slot = 0;
    bars_kept = 0;
    bo_period = 20;
    fast_period = 10;
    slow_period = 50;
    spike_mult = 768;
    score_floor = 0;
    enables = 7;
    gen_close = 1000000;
    trend = 1;
    send_idle = 19;
    recv_idle = 86;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a tick with no history, then short periods and edge-case bars.
    queue_request(tick_request(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    settle();
    write_all(1, 1, 2, 0, 0, 7);
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(pbss_pkg::CFG_BO_PERIOD, 16'hFFC1);
    queue_request(bar_request(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_request(bar_request(0, 32'hFFFF_FFFF, 0, 0));
    queue_request(tick_request(5, 7));
    queue_request(bar_request(200, 100, 150, 1000));
    queue_request(bar_request(180, 120, 160, 1000));
    queue_request(tick_request(400, 3000));
    queue_request(tick_request(20, 0));
    queue_request(tick_request(150, 1000));
    queue_request(tick_request(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_request(tick_request(0, 1));
    queue_request(bar_request(500, 500, 100, 1000));
    queue_request(bar_request(300, 250, 120, 1000));
    queue_request(tick_request(501, 900));
    queue_request(tick_request(499, 2000));
    queue_request(bar_request(300, 250, 90, 1000));
    queue_request(tick_request(249, 1000));
    queue_request(bar_request(600, 100, 200, 1000));
    queue_request(tick_request(100, 1000));
    settle();

    // Defaults again, long history.
    write_all(20, 10, 50, 768, 0, 7);
    queue_random(90, 30);
    settle();

    write_all(3, 2, 5, 256, 0, 7);
    queue_random(70, 35);
    settle();

    send_idle = 86;
    recv_idle = 19;
    write_all(63, 1, 62, 65535, 25600, 5);
    queue_random(40, 30);
    settle();

    // Everything fires and every tick waits behind a stalled receiver.
    write_all(1, 1, 2, 0, 0, 7);
    queue_request(random_tick());
    @(posedge clk);
    long_stall_go <= 1'b1;
    queue_random(40, 60);
    settle();

    send_idle = 0;
    recv_idle = 0;
    write_all(0, 0, 3, 1000, 14000, 6);
    queue_random(30, 40);
    settle();
    write_all(5, 62, 1, 512, 32767, 3);
    queue_random(15, 30);
    settle();

    // A silent stretch gives zero volume and zero close averages.
    write_all(2, 1, 2, 300, 0, 7);
    for (int i = 0; i < 22; i++) queue_request(random_bar(1'b1));
    queue_request(random_tick());
    queue_random(80, 35);
    settle();

    $display("Covered %0d bars and %0d ticks, %0d signals checked,", n_bars, n_ticks, n_signals);
    $display("over eight register settings with stalls on both channels.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Timed out waiting for the scanner.");
    $display("Some tests failed");
    $finish;
  end

endmodule
